// ===== rtl/core/olwm_pkg.sv =====
// olwm_pkg: shared types and constants of the ordered list window mean block
// no dependencies; used by olwm_mean_div and ordered_list_window_mean
`timescale 1ns / 1ps
`default_nettype none

package olwm_pkg;

    // record field widths
    localparam int unsigned ID_W     = 16;
    localparam int unsigned HEIGHT_W = 9;
    localparam int unsigned WEIGHT_W = 8;
    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned REQ_W    = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LIMIT_W  = 9;
    localparam int unsigned MEAN_W   = 9;
    localparam int unsigned COUNT_W  = 9;

    // stream word widths
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned IN_USER_W  = 3;
    localparam int unsigned OUT_DATA_W = 64;
    localparam int unsigned OUT_USER_W = 3;

    // divider step counter
    localparam int unsigned STEP_W = 4;

    // queue limit after reset
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_POS  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REM_HEAD = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REM_POS  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REM_TAIL = 3'd5;
    localparam logic [REQ_W-1:0] REQ_PUSH     = 3'd6;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // one stored record, id in the lowest bits
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [WEIGHT_W-1:0] weight;
        logic [HEIGHT_W-1:0] height;
        logic [ID_W-1:0]     id;
    } t_rec;

    localparam int unsigned REC_W = $bits(t_rec);

endpackage

`default_nettype wire

// ===== rtl/core/ordered_list_window_mean.sv =====
// ordered_list_window_mean: ordered record list in a circular buffer memory,
// with bounded push and rounded mean height per request
// depends on olwm_pkg and olwm_mean_div
//
// channel   dir  handshake             payload
// s         in   i_s_tvalid/o_s_tready i_s_tdata, i_s_tuser (request word)
// m         out  o_m_tvalid/i_m_tready o_m_tdata, o_m_tuser (result word)
// cfg       in   i_cfg_wr_en           i_cfg_wr_data (queue limit)
//
// one request at a time; a positional insert or an inner positional remove also moves the
// records behind the position one by one through the record memory; every request then
// waits on the divider, which skips the division when the list is empty
// reset is synchronous: clears count, sum and head pointer, sets limit to LIMIT_RESET; no clearing pass
// a waiting result does not block acceptance; the next request then holds in its last cycle
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_window_mean #(
    parameter int unsigned LIST_DEPTH = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request word
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // position[7:0], entry_id[23:8], entry_height[32:24], entry_weight[40:33],
    // entry_birth_year[52:41], zero fill
    input  wire logic [olwm_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // req_type[2:0]
    input  wire logic [olwm_pkg::IN_USER_W-1:0]     i_s_tuser,
    // result word
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // removed_id[15:0], removed_height[24:16], removed_weight[32:25],
    // removed_birth_year[44:33], mean_height[53:45], entry_count[62:54], zero fill
    output logic [olwm_pkg::OUT_DATA_W-1:0]         o_m_tdata,
    // removed_valid[0], status[2:1]
    output logic [olwm_pkg::OUT_USER_W-1:0]         o_m_tuser,
    // queue limit register
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [olwm_pkg::LIMIT_W-1:0]       i_cfg_wr_data
);

    localparam int unsigned AW = $clog2(LIST_DEPTH);
    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
    localparam int unsigned SW = olwm_pkg::HEIGHT_W + CW;
    localparam int unsigned XW = (CW > olwm_pkg::POS_W) ? CW : olwm_pkg::POS_W;
    localparam int unsigned LW = (CW > olwm_pkg::LIMIT_W) ? CW : olwm_pkg::LIMIT_W;
    localparam int unsigned KW = (CW > olwm_pkg::COUNT_W) ? CW : olwm_pkg::COUNT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_TAKE   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_APPEND = 3'd4;
    localparam logic [2:0] S_MEAN   = 3'd5;
    localparam logic [2:0] S_WAIT   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    // logical list index to memory address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] lidx);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(lidx);
        if (s >= (CW+1)'(LIST_DEPTH)) begin
            s = s - (CW+1)'(LIST_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // record memory
    olwm_pkg::t_rec mem [LIST_DEPTH];
    olwm_pkg::t_rec r_rd_data;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    olwm_pkg::t_rec mem_wd;
    logic           mem_re;
    logic [AW-1:0]  mem_ra;

    // control and payload registers
    logic [2:0]                      r_state, n_state;
    logic [olwm_pkg::LIMIT_W-1:0]    r_limit;
    logic [AW-1:0]                   r_head, n_head;
    logic [CW-1:0]                   r_count, n_count;
    logic [SW-1:0]                   r_sum, n_sum;
    logic [olwm_pkg::REQ_W-1:0]      r_req, n_req;
    logic [olwm_pkg::POS_W-1:0]      r_pos_in, n_pos_in;
    logic [CW-1:0]                   r_pos, n_pos;
    olwm_pkg::t_rec                  r_rec, n_rec;
    logic [olwm_pkg::STATUS_W-1:0]   r_status, n_status;
    logic                            r_rem_valid, n_rem_valid;
    olwm_pkg::t_rec                  r_rem, n_rem;
    logic                            r_push, n_push;
    logic                            r_dir_up, n_dir_up;
    logic [CW-1:0]                   r_sh_lidx, n_sh_lidx;
    logic [CW-1:0]                   r_wr_lidx, n_wr_lidx;
    logic [CW-1:0]                   r_sh_left, n_sh_left;
    logic                            r_rd_pend, n_rd_pend;
    logic                            r_out_valid, n_out_valid;
    logic [olwm_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [olwm_pkg::OUT_USER_W-1:0] r_out_user, n_out_user;

    // divider hookup
    logic                            div_start;
    logic                            div_done;
    logic [olwm_pkg::MEAN_W-1:0]     div_mean;

    // derived values
    logic                            in_fire;
    logic                            full;
    logic                            empty;
    logic [XW-1:0]                   pos_x;
    logic [XW-1:0]                   cnt_x;
    logic [LW-1:0]                   lim_x;
    logic [LW-1:0]                   cnt_l;
    logic [KW-1:0]                   cnt_k;
    logic [AW-1:0]                   head_inc;
    logic [AW-1:0]                   head_dec;
    logic [SW-1:0]                   h_in;
    logic [SW-1:0]                   h_rd;

    assign in_fire  = i_s_tvalid && o_s_tready;
    assign full     = (r_count == CW'(LIST_DEPTH));
    assign empty    = (r_count == '0);
    assign pos_x    = XW'(r_pos_in);
    assign cnt_x    = XW'(r_count);
    assign cnt_l    = LW'(r_count);
    assign cnt_k    = KW'(r_count);
    assign head_inc = (r_head == AW'(LIST_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign head_dec = (r_head == '0) ? AW'(LIST_DEPTH - 1) : r_head - 1'b1;
    assign h_in     = SW'(r_rec.height);
    assign h_rd     = SW'(r_rd_data.height);

    // effective push limit, clamped to 1..LIST_DEPTH
    always_comb begin
        if (r_limit == '0) begin
            lim_x = LW'(1);
        end else if (LW'(r_limit) > LW'(LIST_DEPTH)) begin
            lim_x = LW'(LIST_DEPTH);
        end else begin
            lim_x = LW'(r_limit);
        end
    end

    // request sequencer
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_sum       = r_sum;
        n_req       = r_req;
        n_pos_in    = r_pos_in;
        n_pos       = r_pos;
        n_rec       = r_rec;
        n_status    = r_status;
        n_rem_valid = r_rem_valid;
        n_rem       = r_rem;
        n_push      = r_push;
        n_dir_up    = r_dir_up;
        n_sh_lidx   = r_sh_lidx;
        n_wr_lidx   = r_wr_lidx;
        n_sh_left   = r_sh_left;
        n_rd_pend   = r_rd_pend;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        mem_we      = 1'b0;
        mem_wa      = phys(r_head, r_count);
        mem_wd      = r_rec;
        mem_re      = 1'b0;
        mem_ra      = phys(r_head, r_pos);
        div_start   = 1'b0;

        // output register drains independently
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_req       = i_s_tuser;
                    n_pos_in    = i_s_tdata[olwm_pkg::POS_W-1:0];
                    n_rec       = i_s_tdata[olwm_pkg::POS_W +: olwm_pkg::REC_W];
                    n_status    = olwm_pkg::ST_OK;
                    n_rem_valid = 1'b0;
                    n_rem       = '0;
                    n_push      = 1'b0;
                    n_state     = S_DECODE;
                end
            end

            S_DECODE: begin
                n_state = S_MEAN;
                unique case (r_req) inside
                    olwm_pkg::REQ_INS_HEAD, olwm_pkg::REQ_INS_POS,
                    olwm_pkg::REQ_INS_TAIL: begin
                        if (full) begin
                            n_status = olwm_pkg::ST_FULL;
                        end else if (r_req == olwm_pkg::REQ_INS_HEAD) begin
                            mem_we  = 1'b1;
                            mem_wa  = head_dec;
                            n_head  = head_dec;
                            n_count = r_count + 1'b1;
                            n_sum   = r_sum + h_in;
                        end else if (r_req == olwm_pkg::REQ_INS_TAIL || pos_x == cnt_x) begin
                            n_state = S_APPEND;
                        end else if (pos_x > cnt_x) begin
                            n_status = olwm_pkg::ST_RANGE;
                        end else begin
                            // open a gap: move records pos..count-1 up by one
                            n_pos     = pos_x[CW-1:0];
                            n_dir_up  = 1'b1;
                            n_sh_lidx = r_count - 1'b1;
                            n_sh_left = r_count - pos_x[CW-1:0];
                            n_rd_pend = 1'b0;
                            n_state   = S_SHIFT;
                        end
                    end
                    olwm_pkg::REQ_REM_HEAD, olwm_pkg::REQ_REM_POS,
                    olwm_pkg::REQ_REM_TAIL: begin
                        if (empty) begin
                            n_status = olwm_pkg::ST_EMPTY;
                        end else if (r_req == olwm_pkg::REQ_REM_POS && pos_x >= cnt_x) begin
                            n_status = olwm_pkg::ST_RANGE;
                        end else begin
                            if (r_req == olwm_pkg::REQ_REM_HEAD) begin
                                n_pos = '0;
                            end else if (r_req == olwm_pkg::REQ_REM_TAIL) begin
                                n_pos = r_count - 1'b1;
                            end else begin
                                n_pos = pos_x[CW-1:0];
                            end
                            mem_re  = 1'b1;
                            mem_ra  = phys(r_head, n_pos);
                            n_state = S_TAKE;
                        end
                    end
                    olwm_pkg::REQ_PUSH: begin
                        if (cnt_l >= lim_x) begin
                            // drop the head first, then append
                            n_pos   = '0;
                            n_push  = 1'b1;
                            mem_re  = 1'b1;
                            mem_ra  = r_head;
                            n_state = S_TAKE;
                        end else begin
                            n_state = S_APPEND;
                        end
                    end
                    default: begin
                        n_state = S_MEAN;
                    end
                endcase
            end

            S_TAKE: begin
                n_rem       = r_rd_data;
                n_rem_valid = 1'b1;
                n_sum       = r_sum - h_rd;
                if (r_pos == '0) begin
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                    n_state = r_push ? S_APPEND : S_MEAN;
                end else begin
                    // close the gap: move records pos+1..count-1 down by one
                    n_dir_up  = 1'b0;
                    n_sh_lidx = r_pos + 1'b1;
                    n_sh_left = r_count - 1'b1 - r_pos;
                    n_rd_pend = 1'b0;
                    n_state   = S_SHIFT;
                end
            end

            S_SHIFT: begin
                // write back the record read in the previous cycle
                if (r_rd_pend) begin
                    mem_we = 1'b1;
                    mem_wa = phys(r_head, r_wr_lidx);
                    mem_wd = r_rd_data;
                end
                if (r_sh_left != '0) begin
                    mem_re    = 1'b1;
                    mem_ra    = phys(r_head, r_sh_lidx);
                    n_wr_lidx = r_dir_up ? r_sh_lidx + 1'b1 : r_sh_lidx - 1'b1;
                    n_sh_lidx = r_dir_up ? r_sh_lidx - 1'b1 : r_sh_lidx + 1'b1;
                    n_sh_left = r_sh_left - 1'b1;
                    n_rd_pend = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                    if (!r_rd_pend) begin
                        if (r_dir_up) begin
                            mem_we  = 1'b1;
                            mem_wa  = phys(r_head, r_pos);
                            mem_wd  = r_rec;
                            n_count = r_count + 1'b1;
                            n_sum   = r_sum + h_in;
                        end else begin
                            n_count = r_count - 1'b1;
                        end
                        n_state = S_MEAN;
                    end
                end
            end

            S_APPEND: begin
                mem_we  = 1'b1;
                mem_wa  = phys(r_head, r_count);
                mem_wd  = r_rec;
                n_count = r_count + 1'b1;
                n_sum   = r_sum + h_in;
                n_state = S_MEAN;
            end

            S_MEAN: begin
                div_start = 1'b1;
                n_state   = S_WAIT;
            end

            S_WAIT: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, cnt_k[olwm_pkg::COUNT_W-1:0], div_mean, r_rem};
                    n_out_user  = {r_status, r_rem_valid};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= olwm_pkg::LIMIT_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_pos_in    <= n_pos_in;
        r_pos       <= n_pos;
        r_rec       <= n_rec;
        r_status    <= n_status;
        r_rem_valid <= n_rem_valid;
        r_rem       <= n_rem;
        r_push      <= n_push;
        r_dir_up    <= n_dir_up;
        r_sh_lidx   <= n_sh_lidx;
        r_wr_lidx   <= n_wr_lidx;
        r_sh_left   <= n_sh_left;
        r_out_data  <= n_out_data;
        r_out_user  <= n_out_user;
    end

    // record memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    // rounded mean of the list after the update
    olwm_mean_div #(
        .CW (CW),
        .SW (SW)
    ) u_mean_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_count (r_count),
        .i_sum   (r_sum),
        .o_done  (div_done),
        .o_mean  (div_mean)
    );

    // ports
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

`default_nettype wire

// ===== rtl/core/olwm_mean_div.sv =====
// olwm_mean_div: rounded mean (2*sum+n)/(2n) by restoring division, one quotient bit a cycle
// depends on olwm_pkg
`timescale 1ns / 1ps
`default_nettype none

module olwm_mean_div #(
    parameter int unsigned CW = 9,
    parameter int unsigned SW = 18
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [CW-1:0]                 i_count,
    input  wire logic [SW-1:0]                 i_sum,
    output logic                               o_done,
    output logic [olwm_pkg::MEAN_W-1:0]        o_mean
);

    localparam int unsigned NW = SW + 2;

    logic                          r_busy;
    logic                          r_done;
    logic [olwm_pkg::STEP_W-1:0]   r_step;
    logic [NW-1:0]                 r_rem;
    logic [NW-1:0]                 r_dsh;
    logic [olwm_pkg::MEAN_W-1:0]   r_q;
    logic                          ge;

    // compare one shifted divisor
    assign ge = (r_rem >= r_dsh);

    // control: busy for one cycle per quotient bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_count == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_step <= olwm_pkg::STEP_W'(olwm_pkg::MEAN_W - 1);
                end
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    // datapath: remainder, shifted divisor and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= (NW'(i_sum) << 1) + NW'(i_count);
            r_dsh <= NW'(i_count) << olwm_pkg::MEAN_W;
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[olwm_pkg::MEAN_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_mean = r_q;

endmodule

`default_nettype wire
